FILE: rtl/egcd_pkg.sv
// Shared types for the extended Euclidean core: controller states, commands and status.
package egcd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_UPDATE
  } egcd_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic update;
    logic finish;
  } egcd_cmd_t;

  typedef struct packed {
    logic r2_zero;
  } egcd_status_t;

endpackage

FILE: rtl/extended_gcd_mod_inverse_core.sv
// Top level of the extended Euclidean core with modular inverses.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid, in_stall  | value_a, value_b
//   out     | out_valid, out_stall| gcd_value, coef_s, coef_t, inv_a_valid,
//           |                     | inv_a_mod_b, inv_b_valid, inv_b_mod_a
//
// Each Euclid step runs a check state, the shift-subtract divider (which builds q*s and q*t
// alongside), and an update state. One item is worked on at a time; the next is taken while
// the result waits in its register. Reset clears the controller and the result valid flag.
module extended_gcd_mod_inverse_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] value_a,
  input  logic signed [DATA_WIDTH-1:0] value_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] gcd_value,
  output logic signed [DATA_WIDTH-1:0] coef_s,
  output logic signed [DATA_WIDTH-1:0] coef_t,
  output logic                         inv_a_valid,
  output logic        [DATA_WIDTH-2:0] inv_a_mod_b,
  output logic                         inv_b_valid,
  output logic        [DATA_WIDTH-2:0] inv_b_mod_a
);
  import egcd_pkg::*;

  egcd_cmd_t    cmd;
  egcd_status_t status;

  egcd_controller #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  egcd_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .value_a    (value_a),
    .value_b    (value_b),
    .gcd_value  (gcd_value),
    .coef_s     (coef_s),
    .coef_t     (coef_t),
    .inv_a_valid(inv_a_valid),
    .inv_a_mod_b(inv_a_mod_b),
    .inv_b_valid(inv_b_valid),
    .inv_b_mod_a(inv_b_mod_a)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Core did not go busy after taking an item.");

  a_inv_a_needs_unit_gcd: assert property (@(posedge clk) disable iff (rst)
    out_valid && inv_a_valid |-> gcd_value == DATA_WIDTH'(1))
    else $error("Inverse of a flagged without a unit gcd.");

  a_inv_a_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inv_a_valid |-> inv_a_mod_b == '0)
    else $error("Invalid inverse of a is not zero.");

  a_inv_b_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inv_b_valid |-> inv_b_mod_a == '0)
    else $error("Invalid inverse of b is not zero.");

endmodule

FILE: rtl/egcd_datapath.sv
// Datapath for the extended Euclidean core: remainder chain, shift-subtract divider and outputs.
module egcd_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  egcd_pkg::egcd_cmd_t          cmd,
  output egcd_pkg::egcd_status_t       status,
  input  logic signed [DATA_WIDTH-1:0] value_a,
  input  logic signed [DATA_WIDTH-1:0] value_b,
  output logic signed [DATA_WIDTH-1:0] gcd_value,
  output logic signed [DATA_WIDTH-1:0] coef_s,
  output logic signed [DATA_WIDTH-1:0] coef_t,
  output logic                         inv_a_valid,
  output logic        [DATA_WIDTH-2:0] inv_a_mod_b,
  output logic                         inv_b_valid,
  output logic        [DATA_WIDTH-2:0] inv_b_mod_a
);
  import egcd_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [W-1:0] r1, r2, s1, s2, t1, t2, op_a, op_b;
  logic [W-1:0] dvd, dsr, rem, acc_s, acc_t;

  logic         neg1, neg2, fits, wrap_q, gcd_one, a_pos, b_pos;
  logic [W:0]   rem_sh, rem_dif;
  logic [W-1:0] rem_next, r_new, qs_s0, qs_t0, qs_s, qs_t, s_new, t_new;
  logic [W-1:0] sum_a, sum_b;

  always_comb begin
    neg1     = r1[W-1];
    neg2     = r2[W-1];
    rem_sh   = {rem, dvd[W-1]};
    fits     = rem_sh >= {1'b0, dsr};
    rem_dif  = rem_sh - {1'b0, dsr};
    rem_next = fits ? rem_dif[W-1:0] : rem_sh[W-1:0];
    wrap_q   = neg1 & (|rem);
    r_new    = wrap_q ? dsr - rem : rem;
    qs_s0    = (neg1 ^ neg2) ? {W{1'b0}} - acc_s : acc_s;
    qs_t0    = (neg1 ^ neg2) ? {W{1'b0}} - acc_t : acc_t;
    qs_s     = wrap_q ? (neg2 ? qs_s0 + s2 : qs_s0 - s2) : qs_s0;
    qs_t     = wrap_q ? (neg2 ? qs_t0 + t2 : qs_t0 - t2) : qs_t0;
    s_new    = s1 - qs_s;
    t_new    = t1 - qs_t;
    gcd_one  = r1 == W'(1);
    a_pos    = !op_a[W-1] && (|op_a);
    b_pos    = !op_b[W-1] && (|op_b);
    sum_a    = op_b + s1;
    sum_b    = op_a + t1;
    status.r2_zero = r2 == '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r1   <= value_a;
      r2   <= value_b;
      op_a <= value_a;
      op_b <= value_b;
      s1   <= W'(1);
      s2   <= '0;
      t1   <= '0;
      t2   <= W'(1);
    end else if (cmd.update) begin
      r1 <= r2;
      r2 <= r_new;
      s1 <= s2;
      s2 <= s_new;
      t1 <= t2;
      t2 <= t_new;
    end
    if (cmd.div_start) begin
      dvd   <= neg1 ? {W{1'b0}} - r1 : r1;
      dsr   <= neg2 ? {W{1'b0}} - r2 : r2;
      rem   <= '0;
      acc_s <= '0;
      acc_t <= '0;
    end else if (cmd.div_step) begin
      dvd   <= {dvd[W-2:0], 1'b0};
      rem   <= rem_next;
      acc_s <= {acc_s[W-2:0], 1'b0} + (fits ? s2 : {W{1'b0}});
      acc_t <= {acc_t[W-2:0], 1'b0} + (fits ? t2 : {W{1'b0}});
    end
    if (cmd.finish) begin
      gcd_value   <= r1;
      coef_s      <= s1;
      coef_t      <= t1;
      inv_a_valid <= gcd_one && b_pos;
      inv_b_valid <= gcd_one && a_pos;
      inv_a_mod_b <= (gcd_one && b_pos) ? (s1[W-1] ? sum_a[W-2:0] : s1[W-2:0]) : '0;
      inv_b_mod_a <= (gcd_one && a_pos) ? (t1[W-1] ? sum_b[W-2:0] : t1[W-2:0]) : '0;
    end
  end

endmodule

FILE: rtl/egcd_controller.sv
// Controller for the extended Euclidean core: step sequencing, bit counter and handshakes.
module egcd_controller #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  egcd_pkg::egcd_status_t status,
  output egcd_pkg::egcd_cmd_t    cmd
);
  import egcd_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  egcd_state_t state, state_next;
  logic [CW-1:0] cnt;
  logic          last_bit, slot_free;

  assign last_bit  = cnt == CW'(DATA_WIDTH - 1);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.r2_zero) state_next = ST_DIVIDE;
        else if (slot_free) state_next = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (last_bit) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.div_start = !status.r2_zero;
        cmd.finish    = status.r2_zero && slot_free;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cmd.div_start) cnt <= '0;
      else if (cmd.div_step) cnt <= cnt + CW'(1);
    end
  end

endmodule
